### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked checks; the module must have clk and rst_n in scope.

`define ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/htwd_pkg.sv
package htwd_pkg;

    localparam int NODES     = 512;
    localparam int ADDR_W    = $clog2(NODES);
    localparam int IDX_W     = 9;
    localparam int SYM_W     = 8;
    localparam int COUNT_W   = 48;
    localparam int CFG_W     = 48;
    localparam int BYTE_BITS = 8;
    localparam int TOP_BIT   = 7;
    localparam int BITS_W    = $clog2(BYTE_BITS + 1);

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_DECODE  = 2'd2
    } cmd_t;

    typedef enum logic {
        REG_ROOT  = 1'b0,
        REG_LIMIT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FLUSH
    } walk_state_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [IDX_W-1:0] node_index;
        logic             node_is_leaf;
        logic [SYM_W-1:0] node_symbol;
        logic [IDX_W-1:0] left_child;
        logic             left_present;
        logic [IDX_W-1:0] right_child;
        logic             right_present;
        logic [SYM_W-1:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             done_res;
    } result_t;

    // One tree node as held in the node store (29 bits).
    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] left_child;
        logic             left_present;
        logic [IDX_W-1:0] right_child;
        logic             right_present;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    // Walk -> output stage.
    typedef struct packed {
        logic             emit;
        logic             flush;
        logic [SYM_W-1:0] symbol;
        logic             done;
    } emit_t;

endpackage

### hdl/huffman_tree_walk_decoder_core.sv
// Tree-walk Huffman decoder. Load the code tree with write-node transactions
// (cmd 0), set root_index and symbol_limit through the config port, issue a
// restart (cmd 1), then feed compressed bytes with decode transactions
// (cmd 2). A transaction is taken when start is high and busy is low. Write
// and restart leave busy low. A decode keeps busy high while it walks the
// byte: each bit walked and each leaf reached is one dependent read of the
// single-port-read node store, and a flush state then closes the decode out.
// Decoded symbols come out on result with result_valid high for exactly one
// cycle each; there is no backpressure, so the receiver must take every
// strobe. The last symbol of a byte carries last=1 and appears in the first
// cycle with busy low; each other symbol appears in the cycle after the walk
// finds the following leaf. done_res flags that the
// decoded count has reached symbol_limit; further bits are then ignored.
// Node store entries are undefined until written.
module huffman_tree_walk_decoder_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  htwd_pkg::item_t            item,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [htwd_pkg::CFG_W-1:0] cfg_data,
    output logic                       result_valid,
    output htwd_pkg::result_t          result
);
    import htwd_pkg::*;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    node_t             ram_wdata;
    node_t             ram_rdata;
    emit_t             emit;

    // Node store: one write port for tree loading, one registered read port
    // for the walk.
    htwd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODES)
    ) u_node_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Walk sequencer: command decode, config registers, position and count.
    htwd_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .emit      (emit)
    );

    // Result stage: holds one symbol back to mark the last of each byte.
    htwd_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .emit         (emit),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

### hdl/htwd_ram.sv
module htwd_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/htwd_walk.sv
`include "assert_macros.svh"

module htwd_walk (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  htwd_pkg::item_t               item,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [htwd_pkg::CFG_W-1:0]    cfg_data,
    output logic                          ram_we,
    output logic [htwd_pkg::ADDR_W-1:0]   ram_waddr,
    output htwd_pkg::node_t               ram_wdata,
    output logic [htwd_pkg::ADDR_W-1:0]   ram_raddr,
    input  htwd_pkg::node_t               ram_rdata,
    output htwd_pkg::emit_t               emit
);
    import htwd_pkg::*;

    walk_state_t          state_reg, state_next;
    logic [IDX_W-1:0]     walk_reg, walk_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [BITS_W-1:0]    bits_reg, bits_next;
    logic [SYM_W-1:0]     data_reg, data_next;
    logic                 check_reg, check_next;
    logic                 rd_ok_reg;
    logic [IDX_W-1:0]     root_reg;
    logic [COUNT_W-1:0]   limit_reg;

    logic [IDX_W-1:0]     rd_idx;
    node_t                node;
    logic                 accept;
    logic                 cur_bit;
    logic                 has_child;
    logic [IDX_W-1:0]     child;
    logic [COUNT_W-1:0]   count_inc;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    // Positions beyond the store read as an empty node.
    assign node      = rd_ok_reg ? ram_rdata : '0;
    assign cur_bit   = data_reg[TOP_BIT];
    assign has_child = cur_bit ? node.right_present : node.left_present;
    assign child     = cur_bit ? node.right_child : node.left_child;
    assign count_inc = count_reg + COUNT_W'(1);

    // Node write port.
    assign ram_we    = accept && (item.cmd == CMD_WRITE)
                       && ({1'b0, item.node_index} < (IDX_W+1)'(NODES));
    assign ram_waddr = item.node_index[ADDR_W-1:0];
    always_comb
    begin
        ram_wdata.leaf          = item.node_is_leaf;
        ram_wdata.symbol        = item.node_symbol;
        ram_wdata.left_child    = item.left_child;
        ram_wdata.left_present  = item.left_present;
        ram_wdata.right_child   = item.right_child;
        ram_wdata.right_present = item.right_present;
    end
    assign ram_raddr = rd_idx[ADDR_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        walk_next   = walk_reg;
        count_next  = count_reg;
        bits_next   = bits_reg;
        data_next   = data_reg;
        check_next  = check_reg;
        rd_idx      = walk_reg;
        emit        = '0;
        emit.symbol = node.symbol;
        emit.done   = (count_inc >= limit_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.cmd)
                        CMD_RESTART:
                        begin
                            walk_next  = root_reg;
                            count_next = '0;
                        end
                        CMD_DECODE:
                        begin
                            state_next = ST_EVAL;
                            bits_next  = BITS_W'(BYTE_BITS);
                            data_next  = item.data_byte;
                            check_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EVAL:
            begin
                if (check_reg && node.leaf)
                begin
                    // child just reached is a leaf: emit, back to root
                    emit.emit  = 1'b1;
                    count_next = count_inc;
                    walk_next  = root_reg;
                    check_next = 1'b0;
                    rd_idx     = root_reg;
                end
                else if ((bits_reg == '0) || (count_reg >= limit_reg))
                begin
                    state_next = ST_FLUSH;
                    check_next = 1'b0;
                end
                else
                begin
                    bits_next = bits_reg - BITS_W'(1);
                    data_next = {data_reg[TOP_BIT-1:0], 1'b0};
                    if (has_child)
                    begin
                        walk_next  = child;
                        check_next = 1'b1;
                        rd_idx     = child;
                    end
                    else
                    begin
                        walk_next  = root_reg;
                        check_next = 1'b0;
                        rd_idx     = root_reg;
                    end
                end
            end
            ST_FLUSH:
            begin
                emit.flush = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            walk_reg  <= '0;
            count_reg <= '0;
            bits_reg  <= '0;
            check_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
            root_reg  <= '0;
            limit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
            count_reg <= count_next;
            bits_reg  <= bits_next;
            check_reg <= check_next;
            rd_ok_reg <= ({1'b0, rd_idx} < (IDX_W+1)'(NODES));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROOT:  root_reg  <= cfg_data[IDX_W-1:0];
                    REG_LIMIT: limit_reg <= cfg_data[COUNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    `ASSERT_IMPLIES(a_emit_below_limit, emit.emit, count_reg < limit_reg)
    `ASSERT_HOLDS(a_bits_range, bits_reg <= BITS_W'(BYTE_BITS))
    `ASSERT_NEXT(a_flush_ends, state_reg == ST_FLUSH, state_reg == ST_IDLE)

endmodule

### hdl/htwd_out.sv
`include "assert_macros.svh"

module htwd_out (
    input  logic              clk,
    input  logic              rst_n,
    input  htwd_pkg::emit_t   emit,
    output logic              result_valid,
    output htwd_pkg::result_t result
);
    import htwd_pkg::*;

    // One symbol is held back until we know whether it ends the transaction.
    logic             pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0] pend_sym_reg, pend_sym_next;
    logic             pend_done_reg, pend_done_next;
    logic             result_valid_reg, result_valid_next;
    result_t          result_reg, result_next;

    always_comb
    begin
        pend_valid_next      = pend_valid_reg;
        pend_sym_next        = pend_sym_reg;
        pend_done_next       = pend_done_reg;
        result_valid_next    = 1'b0;
        result_next.symbol   = pend_sym_reg;
        result_next.done_res = pend_done_reg;
        result_next.last     = emit.flush;
        if (emit.emit)
        begin
            result_valid_next = pend_valid_reg;
            pend_valid_next   = 1'b1;
            pend_sym_next     = emit.symbol;
            pend_done_next    = emit.done;
        end
        else if (emit.flush)
        begin
            result_valid_next = pend_valid_reg;
            pend_valid_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_sym_reg  <= pend_sym_next;
        pend_done_reg <= pend_done_next;
        result_reg    <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_NEXT(a_out_from_pend, emit.emit || emit.flush,
                 result_valid_reg == $past(pend_valid_reg))
    `ASSERT_NEXT(a_flush_empties, emit.flush && !emit.emit, !pend_valid_reg)
    `ASSERT_HOLDS(a_no_overlap, !(emit.emit && emit.flush))

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

// Tree-walk decoder bench. The tree is loaded with write-node transactions and
// then walked by decode transactions; a local tree-walk predictor builds the
// symbols that each accepted transaction should produce. Results are checked in
// order, field by field.
module tb;

    import htwd_pkg::*;

    // Code 3 is unused by the block and must be ignored.
    localparam logic [1:0]         CMD_UNUSED = 2'd3;
    localparam logic [CFG_W-1:0]   LIMIT_MAX  = {CFG_W{1'b1}};
    // A decode's last symbol comes out after busy has dropped.
    localparam int                 SETTLE_CYCLES = 24;
    localparam int                 DRAIN_LIMIT   = 2000;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    item_t           item = '0;
    logic            cfg_we = 1'b0;
    logic            cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic            result_valid;
    result_t         result;

    huffman_tree_walk_decoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor state: our own copy of the node store, walk and count.
    // ---------------------------------------------------------------
    node_t              tree_nodes [NODES];
    logic [IDX_W-1:0]   walk_at;
    logic [IDX_W-1:0]   root_sel;
    logic [COUNT_W-1:0] decoded_total;
    logic [COUNT_W-1:0] limit_sel;

    result_t            pending_symbols [$];
    int                 mismatches = 0;
    int                 gap_pct = 0;

    // Stimulus bookkeeping for the tree currently in use. Only nodes of this
    // tree are reachable from the root, so noise writes go elsewhere.
    bit                 tree_member [NODES];
    logic [IDX_W-1:0]   leaf_slots [$];

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Walk one accepted transaction through the local tree copy and queue the
    // symbols it should emit.
    task automatic predict_transaction(input item_t it);
        node_t   cur;
        node_t   nxt;
        logic    go_right;
        logic    has_child;
        result_t sym;
        int      emitted;

        emitted = 0;
        if (it.cmd == CMD_WRITE)
        begin
            tree_nodes[it.node_index] = '{leaf: it.node_is_leaf, symbol: it.node_symbol,
                                          left_child: it.left_child,
                                          left_present: it.left_present,
                                          right_child: it.right_child,
                                          right_present: it.right_present};
        end
        else if (it.cmd == CMD_RESTART)
        begin
            walk_at = root_sel;
            decoded_total = '0;
        end
        else if (it.cmd == CMD_DECODE)
        begin
            for (int b = TOP_BIT; b >= 0; b--)
            begin
                // once the count reaches the limit, remaining bits are padding
                if (decoded_total >= limit_sel)
                    break;
                cur = tree_nodes[walk_at];
                go_right = it.data_byte[b];
                has_child = go_right ? cur.right_present : cur.left_present;
                if (!has_child)
                begin
                    // missing child: back to root, nothing emitted
                    walk_at = root_sel;
                    continue;
                end
                walk_at = go_right ? cur.right_child : cur.left_child;
                nxt = tree_nodes[walk_at];
                if (nxt.leaf)
                begin
                    decoded_total = decoded_total + 1'b1;
                    sym.symbol = nxt.symbol;
                    sym.last = 1'b0;
                    sym.done_res = (decoded_total >= limit_sel);
                    pending_symbols.push_back(sym);
                    emitted++;
                    walk_at = root_sel;
                end
            end
            if (emitted > 0)
            begin
                sym = pending_symbols.pop_back();
                sym.last = 1'b1;
                pending_symbols.push_back(sym);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Result checker: every strobe is compared with the oldest expectation.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_symbols.size() == 0)
            begin
                note_failure($sformatf("unexpected symbol %02h last=%0b done=%0b",
                                       result.symbol, result.last, result.done_res));
            end
            else
            begin
                want = pending_symbols.pop_front();
                if (result.symbol !== want.symbol || result.last !== want.last ||
                    result.done_res !== want.done_res)
                begin
                    note_failure($sformatf(
                        "expected sym=%02h last=%0b done=%0b, got sym=%02h last=%0b done=%0b",
                        want.symbol, want.last, want.done_res,
                        result.symbol, result.last, result.done_res));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------

    // One command transaction: optional idle gap, then hold start until the
    // block is not busy at a rising edge. start stays high on return so that
    // a following transaction can go out back to back.
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_transaction(it);
    endtask

    // Drop start, wait until every expected symbol has arrived and the block
    // has closed out its last decode.
    task automatic settle_idle();
        int waited;
        start <= 1'b0;
        waited = 0;
        while ((busy || pending_symbols.size() != 0) && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT)
        begin
            note_failure($sformatf("%0d expected symbols never arrived",
                                   pending_symbols.size()));
            pending_symbols.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t which, input logic [CFG_W-1:0] value);
        settle_idle();
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (which == REG_ROOT)
            root_sel = value[IDX_W-1:0];
        else
            limit_sel = value[COUNT_W-1:0];
    endtask

    function automatic item_t random_item(input logic [1:0] code);
        logic [63:0] raw;
        item_t       it;
        raw = {$urandom, $urandom};
        it = raw[$bits(item_t)-1:0];
        it.cmd = code;
        return it;
    endfunction

    task automatic put_node(input logic [IDX_W-1:0] idx, input logic is_leaf,
                            input logic [SYM_W-1:0] sym,
                            input logic [IDX_W-1:0] lchild, input logic lpres,
                            input logic [IDX_W-1:0] rchild, input logic rpres);
        item_t it;
        it = random_item(CMD_WRITE);
        it.node_index = idx;
        it.node_is_leaf = is_leaf;
        it.node_symbol = sym;
        it.left_child = lchild;
        it.left_present = lpres;
        it.right_child = rchild;
        it.right_present = rpres;
        send_item(it);
    endtask

    task automatic send_decode(input logic [SYM_W-1:0] bits);
        item_t it;
        it = random_item(CMD_DECODE);
        it.data_byte = bits;
        send_item(it);
    endtask

    task automatic send_restart();
        send_item(random_item(CMD_RESTART));
    endtask

    function automatic logic [CFG_W-1:0] pick_limit();
        logic [63:0] raw;
        int          pick;
        raw = {$urandom, $urandom};
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        else if (pick <= 3)
            return CFG_W'($urandom_range(1, 30));
        else if (pick == 4)
            return LIMIT_MAX;
        return raw[CFG_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] claim_slot();
        logic [IDX_W-1:0] slot;
        do
            slot = IDX_W'($urandom_range(NODES - 1));
        while (tree_member[slot]);
        tree_member[slot] = 1'b1;
        return slot;
    endfunction

    // Random code tree at random store slots: leaves first, then subtrees are
    // joined pairwise under new internal nodes. Now and then a join drops one
    // child so that walks hit missing children.
    task automatic build_random_tree(output logic [IDX_W-1:0] top);
        logic [IDX_W-1:0] subtrees [$];
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] slot;
        logic             swap;
        int               pick;
        int               drop;

        foreach (tree_member[i])
            tree_member[i] = 1'b0;
        leaf_slots.delete();
        repeat ($urandom_range(2, 9))
        begin
            slot = claim_slot();
            put_node(slot, 1'b1, SYM_W'($urandom), IDX_W'($urandom), 1'b0,
                     IDX_W'($urandom), 1'b0);
            subtrees.push_back(slot);
            leaf_slots.push_back(slot);
        end
        while (subtrees.size() > 1)
        begin
            pick = $urandom_range(subtrees.size() - 1);
            a = subtrees[pick];
            subtrees.delete(pick);
            pick = $urandom_range(subtrees.size() - 1);
            b = subtrees[pick];
            subtrees.delete(pick);
            swap = $urandom_range(1);
            if (swap)
            begin
                slot = a;
                a = b;
                b = slot;
            end
            drop = $urandom_range(11);
            slot = claim_slot();
            put_node(slot, 1'b0, SYM_W'($urandom), a, drop != 0, b, drop != 1);
            subtrees.push_back(slot);
        end
        top = subtrees[0];
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Hand-built tree:
    //   0   : internal, zero -> 1, one -> 511
    //   1   : leaf 00
    //   511 : internal, zero -> 2, one missing
    //   2   : leaf FF (children present but never followed)
    //   3   : leaf 5A with no children, used as a root
    task automatic test_directed();
        gap_pct = 0;
        put_node(9'd0, 1'b0, 8'h00, 9'd1, 1'b1, 9'd511, 1'b1);
        put_node(9'd1, 1'b1, 8'h00, 9'd0, 1'b0, 9'd0, 1'b0);
        put_node(9'd511, 1'b0, 8'hFF, 9'd2, 1'b1, 9'd511, 1'b0);
        put_node(9'd2, 1'b1, 8'hFF, 9'd511, 1'b1, 9'd511, 1'b1);
        // limit is zero out of reset: nothing may be decoded
        send_decode(8'h00);

        write_register(REG_ROOT, '0);
        write_register(REG_LIMIT, LIMIT_MAX);
        send_restart();
        send_decode(8'h00);         // eight symbols from one byte
        send_decode(8'hFF);         // missing child on every other bit, no output
        send_decode(8'b1001_0110);  // mixed paths with one missing child
        send_decode(8'h80);
        send_item(random_item(CMD_UNUSED));
        send_restart();

        // limit reached mid-byte; the rest is padding
        write_register(REG_LIMIT, 48'd3);
        send_restart();
        send_decode(8'h00);
        send_decode(8'h00);

        // limit lowered below the count already decoded
        write_register(REG_LIMIT, 48'd5);
        send_restart();
        send_decode(8'h00);
        write_register(REG_LIMIT, 48'd2);
        send_decode(8'h00);

        // leaf as root: no child on either side, root is not taken as a symbol
        put_node(9'd3, 1'b1, 8'h5A, 9'd0, 1'b0, 9'd0, 1'b0);
        write_register(REG_ROOT, 48'd3);
        write_register(REG_LIMIT, LIMIT_MAX);
        send_restart();
        send_decode(8'h3C);

        // root at the top index
        write_register(REG_ROOT, 48'd511);
        send_restart();
        send_decode(8'h00);
        send_decode(8'h7F);

        write_register(REG_LIMIT, '0);
        send_restart();
        send_decode(8'hA5);
    endtask

    // Rounds of: fresh random tree, new root and limit, restart, then a stream
    // that is mostly decodes with some restarts, leaf rewrites, limit changes and noise.
    task automatic test_random_trees(input int idle_pct, input int stream_items);
        logic [IDX_W-1:0] top;
        logic [IDX_W-1:0] slot;
        item_t            it;
        int               sent;
        int               pick;

        gap_pct = idle_pct;
        sent = 0;
        while (sent < stream_items)
        begin
            settle_idle();
            build_random_tree(top);
            write_register(REG_ROOT, CFG_W'(top));
            write_register(REG_LIMIT, pick_limit());
            send_restart();
            repeat ($urandom_range(10, 20))
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    send_decode(SYM_W'($urandom));
                end
                else if (pick < 78)
                begin
                    send_restart();
                end
                else if (pick < 83)
                begin
                    send_item(random_item(CMD_UNUSED));
                end
                else if (pick < 91)
                begin
                    // new symbol on a leaf of the live tree
                    slot = leaf_slots[$urandom_range(leaf_slots.size() - 1)];
                    put_node(slot, 1'b1, SYM_W'($urandom), IDX_W'($urandom), 1'b0,
                             IDX_W'($urandom), 1'b0);
                end
                else if (pick < 96)
                begin
                    // arbitrary node outside the live tree: never reached
                    it = random_item(CMD_WRITE);
                    while (tree_member[it.node_index])
                        it.node_index = IDX_W'($urandom);
                    send_item(it);
                end
                else if (pick < 98)
                begin
                    write_register(REG_LIMIT, pick_limit());
                end
                else
                begin
                    // hold off until the block has delivered everything
                    settle_idle();
                end
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        foreach (tree_nodes[i])
            tree_nodes[i] = '0;
        foreach (tree_member[i])
            tree_member[i] = 1'b0;
        walk_at = '0;
        root_sel = '0;
        decoded_total = '0;
        limit_sel = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_trees(20, 30);
        test_random_trees(60, 30);
        test_random_trees(0, 30);
        settle_idle();

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
